// ===== hdl/ckts_pkg.sv =====
// shared types and constants for the checked identifier timestamp table
// no dependencies
package ckts_pkg;

   localparam int ID_W              = 16;
   localparam int TIME_W            = 32;
   localparam int SLOT_W            = 6;
   localparam int DEF_TABLE_ENTRIES = 64;

   localparam logic OP_LOOKUP = 1'b0;
   localparam logic OP_MARK   = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_WAIT,
      ST_WRITE
   } state_type;

   typedef struct packed {
      logic clear;
      logic valid;
   } scan_ctl_type;

endpackage

// ===== hdl/ckts_table_mem.sv =====
// table storage: one synchronous memory holding identifier and tick per entry
// one write port, one read port, read data registered; depends on nothing
module ckts_table_mem #(
   parameter int DEPTH = 64,
   parameter int AW    = 6,
   parameter int DW    = 48
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [DW-1:0] wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [DW-1:0] rd_data
);

   logic [DW-1:0] mem_ff [DEPTH];
   logic [DW-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/ckts_scan.sv =====
// scan unit: checks each entry read back for the key and tracks the replacement victim
// depends on ckts_pkg
module ckts_scan
   import ckts_pkg::*;
#(
   parameter int AW = 6
) (
   input  logic                clock,
   input  logic                reset,
   input  scan_ctl_type        ctl,
   input  logic [ID_W-1:0]     key_id,
   input  logic [TIME_W-1:0]   start_now,
   input  logic [AW-1:0]       rd_idx,
   input  logic [ID_W-1:0]     rd_id,
   input  logic [TIME_W-1:0]   rd_time,
   output logic                hit,
   output logic [AW-1:0]       hit_idx,
   output logic [TIME_W-1:0]   hit_time,
   output logic [AW-1:0]       victim_idx
);

   logic              hit_ff, hit_in;
   logic [AW-1:0]     hit_idx_ff, hit_idx_in;
   logic [TIME_W-1:0] hit_time_ff, hit_time_in;
   logic [TIME_W:0]   best_ff, best_in;
   logic [AW-1:0]     victim_ff, victim_in;

   always_comb begin
      hit_in      = hit_ff;
      hit_idx_in  = hit_idx_ff;
      hit_time_in = hit_time_ff;
      best_in     = best_ff;
      victim_in   = victim_ff;
      if (ctl.clear) begin
         hit_in    = 1'b0;
         best_in   = {1'b0, start_now} + (TIME_W+1)'(1);
         victim_in = '0;
      end else if (ctl.valid) begin
         if (!hit_ff && rd_id == key_id) begin
            hit_in      = 1'b1;
            hit_idx_in  = rd_idx;
            hit_time_in = rd_time;
         end
         if ({1'b0, rd_time} < best_ff) begin
            best_in   = {1'b0, rd_time};
            victim_in = rd_idx;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff <= 1'b0;
      end else begin
         hit_ff <= hit_in;
      end
   end

   always_ff @(posedge clock) begin
      hit_idx_ff  <= hit_idx_in;
      hit_time_ff <= hit_time_in;
      best_ff     <= best_in;
      victim_ff   <= victim_in;
   end

   assign hit        = hit_ff;
   assign hit_idx    = hit_idx_ff;
   assign hit_time   = hit_time_ff;
   assign victim_idx = victim_ff;

endmodule

// ===== hdl/checked_id_timestamp_table.sv =====
// top level of the checked identifier timestamp table: sequencer, fill count, response
// depends on ckts_pkg, ckts_table_mem, ckts_scan
//
// A transaction is taken when start is high and busy is low; it reads every filled
// entry of the table through the single read port of the table memory, one entry per
// cycle, then decides and writes back in the write-back state. Busy stays high from
// acceptance through the write-back, so no new item is taken before then. The result
// is shown for exactly one cycle with rsp_strobe high, in the cycle after the
// write-back, and must be captured then: there is no way to hold it. A new
// transaction may be started in the same cycle as that strobe. No clearing pass runs
// after reset; the fill count alone marks which entries are valid.
module checked_id_timestamp_table
   import ckts_pkg::*;
#(
   parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic              req_operation,
   input  logic [ID_W-1:0]   req_item_id,
   input  logic [TIME_W-1:0] req_now,
   output logic              rsp_strobe,
   output logic              rsp_found,
   output logic [TIME_W-1:0] rsp_stamp,
   output logic [SLOT_W-1:0] rsp_slot
);

   localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CW = $clog2(TABLE_ENTRIES + 1);
   localparam int DW = ID_W + TIME_W;

   state_type         state_ff, state_in;
   logic [AW-1:0]     addr_ff, addr_in;
   logic [CW-1:0]     fill_ff, fill_in;
   logic              op_ff;
   logic [ID_W-1:0]   id_ff;
   logic [TIME_W-1:0] now_ff;
   logic              rd_valid_ff;
   logic [AW-1:0]     rd_idx_ff;

   logic              rsp_strobe_ff, rsp_strobe_in;
   logic              rsp_found_ff, rsp_found_in;
   logic [TIME_W-1:0] rsp_stamp_ff, rsp_stamp_in;
   logic [SLOT_W-1:0] rsp_slot_ff, rsp_slot_in;

   logic              accept;
   logic              last_issue;
   logic              rd_en;
   logic              wr_en;
   logic [AW-1:0]     wr_addr;
   logic [DW-1:0]     wr_data;
   logic [DW-1:0]     rd_data;
   scan_ctl_type      scan_ctl;

   logic              hit;
   logic [AW-1:0]     hit_idx;
   logic [TIME_W-1:0] hit_time;
   logic [AW-1:0]     victim_idx;

   assign busy       = (state_ff != ST_IDLE);
   assign accept     = start && !busy;
   assign last_issue = ((CW'(addr_ff) + CW'(1)) == fill_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = (fill_ff == '0) ? ST_WRITE : ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (last_issue) begin
               state_in = ST_WAIT;
            end
         end
         ST_WAIT:  state_in = ST_WRITE;
         ST_WRITE: state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      addr_in        = addr_ff;
      fill_in        = fill_ff;
      rd_en          = 1'b0;
      wr_en          = 1'b0;
      wr_addr        = hit_idx;
      wr_data        = {id_ff, now_ff};
      rsp_strobe_in  = 1'b0;
      rsp_found_in   = rsp_found_ff;
      rsp_stamp_in   = rsp_stamp_ff;
      rsp_slot_in    = rsp_slot_ff;
      scan_ctl.clear = accept;
      scan_ctl.valid = rd_valid_ff;
      case (state_ff)
         ST_IDLE: begin
            addr_in = '0;
         end
         ST_SCAN: begin
            rd_en   = 1'b1;
            addr_in = addr_ff + AW'(1);
         end
         ST_WAIT: begin
            addr_in = addr_ff;
         end
         ST_WRITE: begin
            rsp_strobe_in = 1'b1;
            rsp_found_in  = hit;
            if (op_ff == OP_LOOKUP) begin
               rsp_stamp_in = hit ? hit_time : '0;
               rsp_slot_in  = hit ? SLOT_W'(hit_idx) : '0;
            end else begin
               wr_en        = 1'b1;
               rsp_stamp_in = now_ff;
               if (hit) begin
                  wr_addr = hit_idx;
               end else if (fill_ff != CW'(TABLE_ENTRIES)) begin
                  wr_addr = fill_ff[AW-1:0];
                  fill_in = fill_ff + CW'(1);
               end else begin
                  wr_addr = victim_idx;
               end
               rsp_slot_in = SLOT_W'(wr_addr);
            end
         end
         default: begin
            addr_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         fill_ff       <= '0;
         rd_valid_ff   <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         fill_ff       <= fill_in;
         rd_valid_ff   <= rd_en;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff      <= addr_in;
      rd_idx_ff    <= addr_ff;
      rsp_found_ff <= rsp_found_in;
      rsp_stamp_ff <= rsp_stamp_in;
      rsp_slot_ff  <= rsp_slot_in;
      if (accept) begin
         op_ff  <= req_operation;
         id_ff  <= req_item_id;
         now_ff <= req_now;
      end
   end

   ckts_table_mem #(
      .DEPTH (TABLE_ENTRIES),
      .AW    (AW),
      .DW    (DW)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (addr_ff),
      .rd_data (rd_data)
   );

   ckts_scan #(
      .AW (AW)
   ) u_scan (
      .clock      (clock),
      .reset      (reset),
      .ctl        (scan_ctl),
      .key_id     (id_ff),
      .start_now  (req_now),
      .rd_idx     (rd_idx_ff),
      .rd_id      (rd_data[DW-1:TIME_W]),
      .rd_time    (rd_data[TIME_W-1:0]),
      .hit        (hit),
      .hit_idx    (hit_idx),
      .hit_time   (hit_time),
      .victim_idx (victim_idx)
   );

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_found  = rsp_found_ff;
   assign rsp_stamp  = rsp_stamp_ff;
   assign rsp_slot   = rsp_slot_ff;

`ifndef SYNTH
   a_strobe_after_write: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(state_ff == ST_WRITE))
      else $error("response strobe without a write-back cycle");

   a_scan_needs_entries: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (fill_ff != '0))
      else $error("scan running over an empty table");

   a_fill_bounded: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CW'(TABLE_ENTRIES))
      else $error("fill count beyond table size");

   a_accept_goes_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("transaction accepted but block not busy");

   a_fill_grows_by_one: assert property (@(posedge clock) disable iff (reset)
      (fill_ff != $past(fill_ff)) |-> ($past(state_ff == ST_WRITE && op_ff == OP_MARK && !hit)
                                       && fill_ff == $past(fill_ff) + CW'(1)))
      else $error("fill count changed outside an append");
`endif

endmodule
